FILE: rtl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the matrix-vector transform: item payloads,
// action codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DIM_W     = 3;
  localparam int unsigned RES_MAX   = 4;
  localparam logic [2:0]  COUNT_MAX = 3'd7;

  localparam logic CFG_NUM_COLS = 1'b0;
  localparam logic CFG_NUM_ROWS = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SCALE  = 2'd1,
    ACT_VECTOR = 2'd2,
    ACT_NONE   = 2'd3
  } mvt_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } mvt_state_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [1:0]              row;
    logic [1:0]              col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } mvt_in_t;

  typedef struct packed {
    logic [1:0]              index;
    logic signed [VAL_W-1:0] value_res;
    logic                    last_res;
  } mvt_out_t;

  typedef struct packed {
    logic in_ready;
    logic issue;
    logic out_load;
    logic vec_clear;
  } mvt_ctrl_t;

endpackage

FILE: rtl/mvt_stream_if.sv
// ----------------------------------------------------------------------------
// mvt_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface mvt_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

FILE: rtl/matrix_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform
// Q16.16 matrix held in a synchronous RAM, with entry loads, saturating
// scaling and a streamed matrix-vector product.
// ----------------------------------------------------------------------------
// The input channel in_i takes one beat per item: a load writes one matrix
// entry, a scale multiplies the entries in use by a scalar, and a vector beat
// adds its column's products into the row sums. On a last vector beat, the
// output channel out_o gives one beat per row in use, the final one flagged.
// A vector beat issues one RAM read per row through a read, multiply and
// accumulate pipeline. A scale issues rows times columns entries, one per
// cycle, written back from the end of the same pipeline; the RAM has a single
// read port. After a last vector beat, each result leaves the sequencer one
// per cycle while out_o does not stall. Reset restores the identity matrix
// through per-entry valid bits, clears the row sums and the element count,
// and needs no clearing pass. in_i is ready only between items. A stalled
// out_o holds its beat, and the sequencer waits while the output register is
// full and stalled. The user must write configuration through cfg_we_i only
// while no item is in progress; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module matrix_vector_transform #(
  parameter int unsigned MAX_DIM   = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [mvt_pkg::DIM_W-1:0] cfg_wdata_i,
  mvt_stream_if.sink               in_i,
  mvt_stream_if.source             out_o
);

  import mvt_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic signed [VAL_W-1:0] ONE  = VAL_W'(64'(1) << FRAC_BITS);
  localparam logic signed [63:0]      HALF = (64'(1) << FRAC_BITS) >> 1;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] to_q(logic signed [63:0] v);
    logic signed [63:0] rv;
    logic signed [63:0] r;
    rv = sat_add64(v, HALF);
    r  = rv >>> FRAC_BITS;
    if (r[63:31] != {33{r[63]}}) begin
      return r[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
    return r[31:0];
  endfunction

  mvt_state_e state_q, state_d;
  mvt_ctrl_t  ctrl;

  logic [DIM_W-1:0] num_cols_q, num_rows_q;
  logic [DIM_W-1:0] nc, sr, nr;

  logic [DIM_W-1:0] iss_i_q, iss_i_d, iss_j_q, iss_j_d;
  logic             mode_scale_q, mode_scale_d;
  logic signed [VAL_W-1:0] opnd_q, opnd_d;
  logic [1:0]       col_q, col_d;
  logic             last_q, last_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [1:0]       oidx_q, oidx_d;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] ent_vld_q;
  logic [VAL_W-1:0] rdata_q;
  logic             ent_vld_rd_q;

  logic             s1_vld_q, s1_diag_q;
  logic [AW-1:0]    s1_addr_q;
  logic [1:0]       s1_row_q;
  logic             s2_vld_q;
  logic [AW-1:0]    s2_addr_q;
  logic [1:0]       s2_row_q;
  logic signed [63:0] prod_q;

  logic signed [63:0] sums_q [RES_MAX];

  logic             out_vld_q;
  mvt_out_t         out_q;

  logic             in_acc, slot_free, pipe_empty, issue_last;
  logic [1:0]       col_sel;
  logic [AW-1:0]    rd_addr, ld_addr, wr_addr;
  logic             ld_ok, wr_en;
  logic [VAL_W-1:0] wr_data;
  logic signed [VAL_W-1:0] s1_data;

  always_comb begin
    nc = (int'(num_cols_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : num_cols_q;
    sr = (int'(num_rows_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : num_rows_q;
    nr = (int'(sr) > RES_MAX) ? DIM_W'(RES_MAX) : sr;
  end

  assign in_acc     = in_i.valid && ctrl.in_ready;
  assign slot_free  = !out_vld_q || out_o.ready;
  assign pipe_empty = !s1_vld_q && !s2_vld_q;
  assign issue_last = mode_scale_q ? (iss_i_q == sr - 3'd1 && iss_j_q == nc - 3'd1)
                                   : (iss_i_q == nr - 3'd1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.payload.action)
            ACT_SCALE: begin
              if (sr != '0 && nc != '0) begin
                state_d = ST_ISSUE;
              end
            end
            ACT_VECTOR: begin
              if ({1'b0, in_i.payload.col} < nc && nr != '0) begin
                state_d = ST_ISSUE;
              end else begin
                state_d = ST_DRAIN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ISSUE: begin
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = (!mode_scale_q && last_q && nr != '0) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (slot_free && {1'b0, oidx_q} == nr - 3'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE:  ctrl.in_ready = 1'b1;
      ST_ISSUE: ctrl.issue = 1'b1;
      ST_DRAIN: ctrl.vec_clear = pipe_empty && !mode_scale_q && last_q && nr == '0;
      ST_OUT: begin
        ctrl.out_load  = slot_free;
        ctrl.vec_clear = slot_free && {1'b0, oidx_q} == nr - 3'd1;
      end
      default: ctrl = '0;
    endcase
  end

  assign in_i.ready = ctrl.in_ready;

  always_comb begin
    iss_i_d      = iss_i_q;
    iss_j_d      = iss_j_q;
    mode_scale_d = mode_scale_q;
    opnd_d       = opnd_q;
    col_d        = col_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    oidx_d       = oidx_q;
    if (in_acc) begin
      iss_i_d      = '0;
      iss_j_d      = '0;
      oidx_d       = '0;
      mode_scale_d = in_i.payload.action == ACT_SCALE;
      opnd_d       = in_i.payload.value;
      col_d        = in_i.payload.col;
      last_d       = in_i.payload.last;
      if (in_i.payload.action == ACT_VECTOR && cnt_q != COUNT_MAX) begin
        cnt_d = cnt_q + 3'd1;
      end
    end
    if (ctrl.issue) begin
      if (mode_scale_q && iss_j_q != nc - 3'd1) begin
        iss_j_d = iss_j_q + 3'd1;
      end else begin
        iss_j_d = '0;
        iss_i_d = iss_i_q + 3'd1;
      end
    end
    if (ctrl.out_load) begin
      oidx_d = oidx_q + 2'd1;
    end
    if (ctrl.vec_clear) begin
      cnt_d = '0;
    end
  end

  assign col_sel = mode_scale_q ? iss_j_q[1:0] : col_q;
  assign rd_addr = AW'(int'(iss_i_q) * MAX_DIM + int'(mode_scale_q ? iss_j_q : {1'b0, col_q}));
  assign ld_ok   = int'(in_i.payload.row) < MAX_DIM && int'(in_i.payload.col) < MAX_DIM;
  assign ld_addr = AW'(int'(in_i.payload.row) * MAX_DIM + int'(in_i.payload.col));
  assign s1_data = ent_vld_rd_q ? rdata_q : (s1_diag_q ? ONE : '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_addr_q;
    wr_data = to_q(prod_q);
    if (in_acc && in_i.payload.action == ACT_LOAD && ld_ok) begin
      wr_en   = 1'b1;
      wr_addr = ld_addr;
      wr_data = in_i.payload.value;
    end else if (s2_vld_q && mode_scale_q) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_cols_q   <= DIM_W'(4);
      num_rows_q   <= DIM_W'(4);
      ent_vld_q    <= '0;
      ent_vld_rd_q <= 1'b0;
      iss_i_q      <= '0;
      iss_j_q      <= '0;
      mode_scale_q <= 1'b0;
      last_q       <= 1'b0;
      cnt_q        <= '0;
      oidx_q       <= '0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      for (int k = 0; k < RES_MAX; k++) begin
        sums_q[k] <= '0;
      end
    end else begin
      state_q      <= state_d;
      iss_i_q      <= iss_i_d;
      iss_j_q      <= iss_j_d;
      mode_scale_q <= mode_scale_d;
      last_q       <= last_d;
      cnt_q        <= cnt_d;
      oidx_q       <= oidx_d;
      s1_vld_q     <= ctrl.issue;
      s2_vld_q     <= s1_vld_q;
      ent_vld_rd_q <= ent_vld_q[rd_addr];
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_COLS) begin
          num_cols_q <= cfg_wdata_i;
        end else begin
          num_rows_q <= cfg_wdata_i;
        end
      end
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (ctrl.vec_clear) begin
        for (int k = 0; k < RES_MAX; k++) begin
          sums_q[k] <= '0;
        end
      end else if (s2_vld_q && !mode_scale_q) begin
        sums_q[s2_row_q] <= sat_add64(sums_q[s2_row_q], prod_q);
      end
      if (ctrl.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q    <= opnd_d;
    col_q     <= col_d;
    s1_diag_q <= iss_i_q[1:0] == col_sel && iss_i_q[2] == (mode_scale_q && iss_j_q[2]);
    s1_addr_q <= rd_addr;
    s1_row_q  <= iss_i_q[1:0];
    s2_addr_q <= s1_addr_q;
    s2_row_q  <= s1_row_q;
    prod_q    <= s1_data * opnd_q;
    if (ctrl.out_load) begin
      out_q.index     <= oidx_q;
      out_q.value_res <= (cnt_q == nc) ? to_q(sums_q[oidx_q]) : '0;
      out_q.last_res  <= {1'b0, oidx_q} == nr - 3'd1;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

endmodule

FILE: rtl/mvt_checker.sv
// ----------------------------------------------------------------------------
// mvt_checker
// Port-level checks of the matrix-vector transform, bound to its top level.
// ----------------------------------------------------------------------------
module mvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_index_i,
  input logic [31:0] out_value_i,
  input logic        out_last_i
);

  import mvt_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i) &&
      $stable(out_value_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // No new item is taken while a result vector is still being emitted.
  a_no_accept_mid_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready during result vector");

  // At most four rows, so only a row below the fourth can be followed by more.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_index_i != 2'd3)
    else $error("non-final result with last row index");

  // Loads, scales and ignored items never start a result vector.
  a_no_result_from_matrix_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i != ACT_VECTOR |=> !$rose(out_valid_i))
    else $error("result started by a non-vector item");

endmodule

bind matrix_vector_transform mvt_checker u_mvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.payload.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.payload.index),
  .out_value_i (out_o.payload.value_res),
  .out_last_i  (out_o.payload.last_res)
);

FILE: dv/matrix_vector_transform_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_tb
// Drives loads, scales and vector beats into the matrix-vector transform under
// random source gaps and sink stalls. A behavioral model of the matrix, the
// row sums and the element count predicts every result beat. The run walks a
// short directed table, then random phases at several register settings.
// ----------------------------------------------------------------------------
module matrix_vector_transform_tb;
  import mvt_pkg::*;

  localparam int DIM            = 4;
  localparam int FRAC           = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 34;

  localparam logic signed [31:0] Q_ONE      = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
  localparam logic signed [63:0] Q_MAX_WIDE = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN_WIDE = -64'sd2147483648;
  localparam logic signed [63:0] ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN    = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    mvt_in_t          beat;
    logic             typed;
    logic [3:0][31:0] res;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_idx;
  logic [DIM_W-1:0]     cfg_wdata;

  mvt_stream_if #(.payload_t(mvt_in_t))  in_if ();
  mvt_stream_if #(.payload_t(mvt_out_t)) out_if ();

  logic signed [31:0] mat_q [DIM*DIM];
  logic signed [63:0] sums_q [RES_MAX];
  logic [2:0]         elem_cnt;
  logic [2:0]         cols_reg;
  logic [2:0]         rows_reg;

  mvt_out_t  expected_beats [$];
  stim_row_t stim_rows [$];
  int        mismatches;
  int        idle_cycles;
  int        stall_left;
  int        random_items;
  bit        quiet_phase;

  matrix_vector_transform u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int eff_dim(logic [2:0] d);
    return (d > DIM) ? DIM : int'(d);
  endfunction

  function automatic logic signed [63:0] add_sat64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? ACC_MIN : ACC_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] round_q(logic signed [63:0] v);
    logic signed [63:0] t;
    t = add_sat64(v, 64'sd1 <<< (FRAC - 1));
    t = t >>> FRAC;
    if (t > Q_MAX_WIDE) return Q_MAX;
    if (t < Q_MIN_WIDE) return Q_MIN;
    return t[31:0];
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < DIM * DIM; i++) mat_q[i] = (i / DIM == i % DIM) ? Q_ONE : '0;
    for (int i = 0; i < RES_MAX; i++) sums_q[i] = '0;
    elem_cnt = '0;
    cols_reg = 3'd4;
    rows_reg = 3'd4;
  endfunction

  function automatic void predict_beat(mvt_in_t b);
    logic signed [31:0] val;
    logic signed [63:0] prod;
    int                 nc;
    int                 nr;
    bit                 match;
    mvt_out_t           res;
    val = b.value;
    nc  = eff_dim(cols_reg);
    nr  = eff_dim(rows_reg);
    case (b.action)
      ACT_LOAD: begin
        mat_q[{b.row, b.col}] = val;
      end
      ACT_SCALE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            prod = mat_q[i*DIM+j] * val;
            mat_q[i*DIM+j] = round_q(prod);
          end
        end
      end
      ACT_VECTOR: begin
        if (int'(b.col) < nc) begin
          for (int i = 0; i < nr; i++) begin
            prod = mat_q[i*DIM+b.col] * val;
            sums_q[i] = add_sat64(sums_q[i], prod);
          end
        end
        if (elem_cnt < COUNT_MAX) elem_cnt++;
        if (b.last) begin
          match = (int'(elem_cnt) == nc);
          for (int i = 0; i < nr; i++) begin
            res.index     = 2'(i);
            res.value_res = match ? round_q(sums_q[i]) : '0;
            res.last_res  = (i == nr - 1);
            expected_beats.push_back(res);
          end
          for (int i = 0; i < RES_MAX; i++) sums_q[i] = '0;
          elem_cnt = '0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_beat(mvt_out_t got);
    mvt_out_t want;
    if (expected_beats.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result beat index %0d value %h last %0b",
                 $time, got.index, got.value_res, got.last_res);
      mismatches++;
      return;
    end
    want = expected_beats.pop_front();
    if (got.index !== want.index || got.value_res !== want.value_res ||
        got.last_res !== want.last_res) begin
      if (mismatches < 10)
        $display("%0t: result mismatch: expected index %0d value %h last %0b, got %0d %h %0b",
                 $time, want.index, want.value_res, want.last_res,
                 got.index, got.value_res, got.last_res);
      mismatches++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      default: return Q_ONE;
    endcase
  endfunction

  function automatic logic [31:0] scale_value();
    if ($urandom_range(0, 4) == 0) return rand_value();
    return Q_ONE + $urandom_range(0, 32'h2000) - 32'h1000;
  endfunction

  function automatic mvt_in_t make_beat(mvt_action_e act, logic [1:0] r, logic [1:0] c,
                                        logic [31:0] v, logic l);
    mvt_in_t b;
    b.action = act;
    b.row    = r;
    b.col    = c;
    b.value  = v;
    b.last   = l;
    return b;
  endfunction

  task automatic add_row(mvt_action_e act, logic [1:0] r, logic [1:0] c, logic [31:0] v,
                         logic l, logic typed, logic [3:0][31:0] res);
    stim_row_t s;
    s.beat  = make_beat(act, r, c, v, l);
    s.typed = typed;
    s.res   = res;
    stim_rows.push_back(s);
  endtask

  task automatic send_beat(mvt_in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= b;
    do @(posedge clk); while (!in_if.ready);
    predict_beat(b);
    if (b.action != ACT_NONE) random_items++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [2:0] cols, logic [2:0] rows);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NUM_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cols_reg = cols;
    cfg_idx   <= CFG_NUM_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    rows_reg = rows;
    cfg_we <= 1'b0;
  endtask

  task automatic send_sequence();
    int         kind;
    int         n;
    logic [1:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 3))
        send_beat(make_beat(ACT_LOAD, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            rand_value(), 1'($urandom_range(0, 1))));
    end else if (kind < 27) begin
      send_beat(make_beat(ACT_SCALE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          scale_value(), 1'($urandom_range(0, 1))));
    end else if (kind < 85) begin
      n = (eff_dim(cols_reg) == 0) ? 1 : eff_dim(cols_reg);
      for (int k = 0; k < n; k++) begin
        c = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, n - 1)) : 2'(k);
        send_beat(make_beat(ACT_VECTOR, 2'($urandom_range(0, 3)), c, rand_value(),
                            k == n - 1));
      end
    end else if (kind < 95) begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++)
        send_beat(make_beat(ACT_VECTOR, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            rand_value(), k == n - 1));
    end else begin
      send_beat(make_beat(ACT_NONE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          $urandom, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_phase(logic [2:0] cols, logic [2:0] rows);
    int start;
    wait_drained();
    write_regs(cols, rows);
    quiet_phase = ($urandom_range(0, 3) == 0);
    start = random_items;
    while (random_items - start < PHASE_ITEMS) send_sequence();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_beat(out_if.payload);
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d result beats outstanding",
                 $time, expected_beats.size());
        $display("** matrix_vector_transform: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int queued;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_NUM_COLS;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;
    stall_left    = 0;
    random_items  = 0;
    quiet_phase   = 1'b0;
    reset_model();

    // The identity matrix passes the vector through unchanged.
    add_row(ACT_VECTOR, 2'd0, 2'd0, Q_ONE,         1'b0, 1'b0, '0);
    add_row(ACT_VECTOR, 2'd3, 2'd1, 32'h0002_0000, 1'b0, 1'b0, '0);
    add_row(ACT_VECTOR, 2'd0, 2'd2, 32'hFFFD_0000, 1'b0, 1'b0, '0);
    add_row(ACT_VECTOR, 2'd0, 2'd3, Q_MAX,         1'b1, 1'b1,
            {Q_MAX, 32'hFFFD_0000, 32'h0002_0000, Q_ONE});
    // A short vector gives zeros.
    add_row(ACT_VECTOR, 2'd0, 2'd0, 32'h0005_0000, 1'b1, 1'b1, '0);
    add_row(ACT_NONE,   2'd3, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    add_row(ACT_LOAD,   2'd0, 2'd0, Q_MAX,         1'b1, 1'b0, '0);
    add_row(ACT_LOAD,   2'd0, 2'd1, Q_MAX,         1'b0, 1'b0, '0);
    for (int k = 0; k < 4; k++)
      add_row(ACT_VECTOR, 2'd0, 2'(k), Q_MAX, k == 3, k == 3, {Q_MAX, Q_MAX, Q_MAX, Q_MAX});
    add_row(ACT_LOAD,   2'd3, 2'd3, Q_MIN,         1'b0, 1'b0, '0);
    add_row(ACT_LOAD,   2'd3, 2'd2, Q_MIN,         1'b0, 1'b0, '0);
    for (int k = 0; k < 4; k++)
      add_row(ACT_VECTOR, 2'd0, 2'(k), Q_MIN, k == 3, k == 3, {Q_MAX, Q_MIN, Q_MIN, Q_MIN});
    add_row(ACT_SCALE,  2'd0, 2'd0, Q_MIN,         1'b1, 1'b0, '0);
    // Eight elements saturate the count at seven, so the vector never matches.
    for (int k = 0; k < 8; k++)
      add_row(ACT_VECTOR, 2'd0, 2'(k), rand_value(), k == 7, k == 7, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k]) begin
      queued = expected_beats.size();
      send_beat(stim_rows[k].beat);
      if (stim_rows[k].typed)
        for (int m = queued; m < expected_beats.size(); m++)
          expected_beats[m].value_res = stim_rows[k].res[m-queued];
    end

    random_items = 0;
    run_phase(3'd4, 3'd4);
    run_phase(3'd1, 3'd1);
    run_phase(3'd2, 3'd3);
    run_phase(3'd0, 3'd2);
    run_phase(3'd7, 3'd5);
    run_phase(3'd3, 3'd0);
    run_phase(3'd4, 3'd1);
    run_phase(3'd1, 3'd4);
    run_phase(3'd6, 3'd7);
    wait_drained();

    if (mismatches == 0) begin
      $display("** matrix_vector_transform: PASSED **");
    end else begin
      $display("** matrix_vector_transform: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mvt_pkg.sv
rtl/mvt_stream_if.sv
rtl/matrix_vector_transform.sv
rtl/mvt_checker.sv
dv/matrix_vector_transform_tb.sv
